// ----- hdl/bmd_pkg.sv -----
// Shared types, widths and the per-bit lane update for the box motion direction block.
// No dependencies; used by bmd_front, bmd_cell and box_motion_direction_top.
package bmd_pkg;

   localparam int CW  = 20;   // coordinate width, Q16.4
   localparam int DW  = 22;   // doubled center displacement
   localparam int MW  = 22;   // displacement magnitude
   localparam int SW  = 44;   // squared length
   localparam int QW  = 62;   // u * S, signed
   localparam int RW  = 78;   // residual T - u^2 * S, signed
   localparam int KW  = 15;   // rounded magnitude bits
   localparam int OW  = 16;   // Q1.14 output
   localparam int TSH = 30;   // T = mag^2 << 30
   localparam logic [KW-1:0] ONE_Q14 = KW'(16384);
   // front stages (3) + cells + output register
   localparam int PIPE_DEPTH = 3 + KW + 1;

   typedef struct packed {
      logic signed [RW-1:0] r;
      logic signed [QW-1:0] q;
      logic [KW-1:0]        k;
      logic                 neg;
   } lane_type;

   typedef struct packed {
      logic          valid;
      logic          zero;
      logic [SW-1:0] s;
      lane_type      y;
      lane_type      x;
   } word_type;

   // Try setting bit b of k: u grows by 2^(b+1), so
   // u'^2 S = u^2 S + (uS << (b+2)) + (S << (2b+2)).
   function automatic lane_type lane_step(lane_type l, logic [SW-1:0] s, logic [3:0] b);
      lane_type             o;
      logic signed [RW-1:0] s_r;
      logic signed [RW-1:0] q_r;
      logic signed [RW-1:0] cand;
      logic [4:0]           sh1;
      logic [5:0]           sh2;
      o    = l;
      s_r  = $signed({{(RW-SW){1'b0}}, s});
      q_r  = $signed({{(RW-QW){l.q[QW-1]}}, l.q});
      sh1  = {1'b0, b} + 5'd2;
      sh2  = {1'b0, b, 1'b0} + 6'd2;
      cand = l.r - (q_r <<< sh1) - (s_r <<< sh2);
      if (!cand[RW-1]) begin
         o.r = cand;
         o.q = l.q + $signed({{(QW-SW){1'b0}}, s} << ({1'b0, b} + 5'd1));
         o.k = l.k | (KW'(1) << b);
      end
      return o;
   endfunction

endpackage

// ----- hdl/bmd_front.sv -----
// Front end: box centers, displacement, squares and the start values of the search.
// Depends on bmd_pkg.
module bmd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take,
   input  logic signed [bmd_pkg::CW-1:0]   prev_left,
   input  logic signed [bmd_pkg::CW-1:0]   prev_top,
   input  logic signed [bmd_pkg::CW-1:0]   prev_right,
   input  logic signed [bmd_pkg::CW-1:0]   prev_bottom,
   input  logic signed [bmd_pkg::CW-1:0]   cur_left,
   input  logic signed [bmd_pkg::CW-1:0]   cur_top,
   input  logic signed [bmd_pkg::CW-1:0]   cur_right,
   input  logic signed [bmd_pkg::CW-1:0]   cur_bottom,
   output bmd_pkg::word_type               word_out
);
   import bmd_pkg::*;

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [DW-1:0] dy_ff, dx_ff;
   logic signed [DW-1:0] dy_in, dx_in;
   logic [MW-1:0]        ay, ax;
   logic [SW-1:0]        sy_ff, sx_ff;
   logic                 ny_ff, nx_ff;
   logic [SW-1:0]        s;
   word_type             word_ff, word_in;

   always_comb begin
      dy_in = (DW'(cur_top) + DW'(cur_bottom)) - (DW'(prev_top) + DW'(prev_bottom));
      dx_in = (DW'(cur_left) + DW'(cur_right)) - (DW'(prev_left) + DW'(prev_right));
      ay    = dy_ff[DW-1] ? MW'(-dy_ff) : MW'(dy_ff);
      ax    = dx_ff[DW-1] ? MW'(-dx_ff) : MW'(dx_ff);
   end

   always_comb begin
      s               = sy_ff + sx_ff;
      word_in.valid   = v2_ff;
      word_in.zero    = (s == '0);
      word_in.s       = s;
      word_in.y.k     = '0;
      word_in.y.neg   = ny_ff;
      word_in.y.q     = -$signed({{(QW-SW){1'b0}}, s});
      word_in.y.r     = $signed({{(RW-SW-TSH){1'b0}}, sy_ff, {TSH{1'b0}}})
                        - $signed({{(RW-SW){1'b0}}, s});
      word_in.x.k     = '0;
      word_in.x.neg   = nx_ff;
      word_in.x.q     = word_in.y.q;
      word_in.x.r     = $signed({{(RW-SW-TSH){1'b0}}, sx_ff, {TSH{1'b0}}})
                        - $signed({{(RW-SW){1'b0}}, s});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         word_ff.valid <= 1'b0;
      end else begin
         v1_ff   <= take;
         v2_ff   <= v1_ff;
         word_ff <= word_in;
      end
      dy_ff <= dy_in;
      dx_ff <= dx_in;
      sy_ff <= SW'(ay) * SW'(ay);
      sx_ff <= SW'(ax) * SW'(ax);
      ny_ff <= dy_ff[DW-1];
      nx_ff <= dx_ff[DW-1];
   end

   assign v3_ff    = word_ff.valid;
   assign word_out = word_ff;

`ifndef SYNTHESIS
   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> $past(take, 3))
      else $error("front valid without a taken word");
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && sy_ff == '0 && sx_ff == '0) |=> word_ff.zero)
      else $error("zero length not flagged");
   a_start_k: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (word_ff.y.k == '0 && word_ff.x.k == '0))
      else $error("search does not start at zero");
`endif

endmodule

// ----- hdl/bmd_cell.sv -----
// One cell of the search chain: decides one bit of the rounded magnitude for both lanes.
// Depends on bmd_pkg.
module bmd_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           bit_pos,
   input  bmd_pkg::word_type    word_in_p,
   output bmd_pkg::word_type    word_out
);
   import bmd_pkg::*;

   word_type word_ff, word_in;

   always_comb begin
      word_in   = word_in_p;
      word_in.y = lane_step(word_in_p.y, word_in_p.s, bit_pos);
      word_in.x = lane_step(word_in_p.x, word_in_p.s, bit_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

`ifndef SYNTHESIS
   a_valid_pass: assert property (@(posedge clock) disable iff (reset)
      word_ff.valid |-> $past(word_in_p.valid))
      else $error("cell valid without input");
   a_bit_set_res: assert property (@(posedge clock) disable iff (reset)
      (word_ff.valid && word_ff.y.k > $past(word_in_p.y.k)) |-> !word_ff.y.r[RW-1])
      else $error("accepted bit left negative residual");
   a_k_grows: assert property (@(posedge clock) disable iff (reset)
      word_ff.valid |-> (word_ff.x.k >= $past(word_in_p.x.k)))
      else $error("magnitude bits lost");
`endif

endmodule

// ----- hdl/box_motion_direction_top.sv -----
// Top level of the box motion direction block: front end, search chain, output register.
// Depends on bmd_pkg, bmd_front and bmd_cell.
//
// Takes a pair of boxes on any cycle that start is high; busy is always low, so a word
// may enter every clock. The result appears for one cycle with rsp_valid after passing
// through three front stages (centers, squares, setup), one chain cell per magnitude
// bit (15 cells, each deciding one bit of the rounded unit component by shift, add and
// compare) and an output register. The receiver cannot stall. When the two
// centers coincide the result is a zero vector with rsp_no_motion set.
module box_motion_direction_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [bmd_pkg::CW-1:0] req_prev_left,
   input  logic signed [bmd_pkg::CW-1:0] req_prev_top,
   input  logic signed [bmd_pkg::CW-1:0] req_prev_right,
   input  logic signed [bmd_pkg::CW-1:0] req_prev_bottom,
   input  logic signed [bmd_pkg::CW-1:0] req_cur_left,
   input  logic signed [bmd_pkg::CW-1:0] req_cur_top,
   input  logic signed [bmd_pkg::CW-1:0] req_cur_right,
   input  logic signed [bmd_pkg::CW-1:0] req_cur_bottom,
   output logic                          rsp_valid,
   output logic signed [bmd_pkg::OW-1:0] rsp_dir_y,
   output logic signed [bmd_pkg::OW-1:0] rsp_dir_x,
   output logic                          rsp_no_motion
);
   import bmd_pkg::*;

   word_type               chain [KW+1];
   logic                   valid_ff;
   logic signed [OW-1:0]   dir_y_ff, dir_x_ff, dir_y_in, dir_x_in;
   logic                   no_motion_ff;
   logic [KW-1:0]          qy, qx;
   word_type               last;

   assign busy = 1'b0;

   bmd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (start & ~busy),
      .prev_left   (req_prev_left),
      .prev_top    (req_prev_top),
      .prev_right  (req_prev_right),
      .prev_bottom (req_prev_bottom),
      .cur_left    (req_cur_left),
      .cur_top     (req_cur_top),
      .cur_right   (req_cur_right),
      .cur_bottom  (req_cur_bottom),
      .word_out    (chain[0])
   );

   for (genvar i = 0; i < KW; i++) begin : g_cell
      bmd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bit_pos   (4'(KW - 1 - i)),
         .word_in_p (chain[i]),
         .word_out  (chain[i+1])
      );
   end

   assign last = chain[KW];

   always_comb begin
      qy       = (last.y.k > ONE_Q14) ? ONE_Q14 : last.y.k;
      qx       = (last.x.k > ONE_Q14) ? ONE_Q14 : last.x.k;
      dir_y_in = last.y.neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      dir_x_in = last.x.neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      if (last.zero) begin
         dir_y_in = '0;
         dir_x_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last.valid;
      end
      dir_y_ff     <= dir_y_in;
      dir_x_ff     <= dir_x_in;
      no_motion_ff <= last.zero;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_dir_y     = dir_y_ff;
   assign rsp_dir_x     = dir_x_ff;
   assign rsp_no_motion = no_motion_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_DEPTH))
      else $error("result without a matching request");
   a_still_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_motion) |-> (rsp_dir_y == '0 && rsp_dir_x == '0))
      else $error("no-motion result has nonzero direction");
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dir_y >= -16'sd16384 && rsp_dir_y <= 16'sd16384
                     && rsp_dir_x >= -16'sd16384 && rsp_dir_x <= 16'sd16384))
      else $error("direction component out of range");
`endif

endmodule

// ----- dv/tb_box_motion_direction_top.sv -----
// Testbench for box_motion_direction_top: directed and random box pairs checked against
// an exact-rounding unit-direction predictor. Depends on bmd_pkg and the RTL top.
module tb_box_motion_direction_top;
   import bmd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic signed [CW-1:0] pl, pt, pr, pb, cl, ct, cr, cb;
   } box_pair_type;

   typedef struct {
      logic [OW-1:0] dir_y;
      logic [OW-1:0] dir_x;
      logic          no_motion;
   } direction_type;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 start = 0;
   logic                 busy;
   logic signed [CW-1:0] req_prev_left = '0, req_prev_top = '0;
   logic signed [CW-1:0] req_prev_right = '0, req_prev_bottom = '0;
   logic signed [CW-1:0] req_cur_left = '0, req_cur_top = '0;
   logic signed [CW-1:0] req_cur_right = '0, req_cur_bottom = '0;
   logic                 rsp_valid;
   logic signed [OW-1:0] rsp_dir_y, rsp_dir_x;
   logic                 rsp_no_motion;

   direction_type expected_dirs[$];
   int            fail_count = 0;
   int            cycle_count = 0;

   box_motion_direction_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // q = floor(16384*mag/sqrt(s) + 1/2), searched as 2^30*mag^2 >= (2k-1)^2*s
   function automatic logic [OW-1:0] unit_component(logic signed [22:0] d,
                                                    logic [47:0] s);
      logic [22:0]  mag;
      logic [127:0] lhs, rhs;
      logic [31:0]  lo, hi, k, odd;
      mag = d[22] ? -d : d;
      lhs = ({105'd0, mag} * {105'd0, mag}) << 30;
      lo  = 0;
      hi  = 16384;
      while (lo < hi) begin
         k   = (lo + hi + 1) >> 1;
         odd = 2 * k - 1;
         rhs = {96'd0, odd} * {96'd0, odd} * {80'd0, s};
         if (lhs >= rhs) lo = k;
         else hi = k - 1;
      end
      if (lo > 16384) lo = 16384;
      return d[22] ? OW'(-lo) : OW'(lo);
   endfunction

   function automatic direction_type predict_direction(box_pair_type b);
      direction_type      r;
      logic signed [22:0] dy, dx;
      logic [47:0]        s;
      dy = (23'(b.ct) + 23'(b.cb)) - (23'(b.pt) + 23'(b.pb));
      dx = (23'(b.cl) + 23'(b.cr)) - (23'(b.pl) + 23'(b.pr));
      s  = 48'(48'(dy) * 48'(dy)) + 48'(48'(dx) * 48'(dx));
      if (s == 0) begin
         r.dir_y = '0;
         r.dir_x = '0;
         r.no_motion = 1'b1;
      end else begin
         r.dir_y = unit_component(dy, s);
         r.dir_x = unit_component(dx, s);
         r.no_motion = 1'b0;
      end
      return r;
   endfunction

   // accepted words get their expectation here, sampled on the accepting edge
   always @(posedge clock) begin
      box_pair_type b;
      cycle_count <= cycle_count + 1;
      if (!reset && start && !busy) begin
         b = '{req_prev_left, req_prev_top, req_prev_right, req_prev_bottom,
               req_cur_left, req_cur_top, req_cur_right, req_cur_bottom};
         expected_dirs.push_back(predict_direction(b));
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** box_motion_direction_top: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      direction_type e;
      if (!reset && rsp_valid) begin
         if (expected_dirs.size() == 0) begin
            $error("result word with no expectation pending");
            fail_count++;
         end else begin
            e = expected_dirs.pop_front();
            if (rsp_dir_y !== e.dir_y) begin
               $error("dir_y expected %0d actual %0d", $signed(e.dir_y), rsp_dir_y);
               fail_count++;
            end
            if (rsp_dir_x !== e.dir_x) begin
               $error("dir_x expected %0d actual %0d", $signed(e.dir_x), rsp_dir_x);
               fail_count++;
            end
            if (rsp_no_motion !== e.no_motion) begin
               $error("no_motion expected %0b actual %0b", e.no_motion, rsp_no_motion);
               fail_count++;
            end
         end
      end
   end

   // start stays high across back-to-back words
   task automatic send_box_pair(box_pair_type b);
      start           <= 1'b1;
      req_prev_left   <= b.pl;
      req_prev_top    <= b.pt;
      req_prev_right  <= b.pr;
      req_prev_bottom <= b.pb;
      req_cur_left    <= b.cl;
      req_cur_top     <= b.ct;
      req_cur_right   <= b.cr;
      req_cur_bottom  <= b.cb;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // step past the accepting edge first so the last accepted word is already queued
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_dirs.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] rand_coord(int span);
      if (span == 0) return CW'($urandom);
      return CW'($urandom_range(2 * span) - span);
   endfunction

   task automatic test_directed();
      localparam logic signed [CW-1:0] MAXC = 20'sh7FFFF;
      localparam logic signed [CW-1:0] MINC = 20'sh80000;
      send_box_pair('{0, 0, 0, 0, 0, 0, 0, 0});                       // coincident
      send_box_pair('{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC});
      send_box_pair('{MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC});
      send_box_pair('{MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC});
      send_box_pair('{MINC, MAXC, MINC, MAXC, MAXC, MINC, MAXC, MINC});
      send_box_pair('{0, 0, 0, 0, 1, 0, 0, 0});                       // pure +x
      send_box_pair('{0, 0, 0, 0, -1, 0, 0, 0});                      // pure -x
      send_box_pair('{0, 0, 0, 0, 0, 1, 0, 0});                       // pure +y
      send_box_pair('{0, 0, 0, 0, 0, -1, 0, 0});                      // pure -y
      send_box_pair('{0, 0, 0, 0, 1, 1, 0, 0});                       // diagonal
      send_box_pair('{0, 0, 0, 0, -3, 4, 0, 0});
      send_box_pair('{0, 0, 0, 0, 1, -100000, 0, 0});                 // tiny x part
      send_box_pair('{100, 100, 50, 50, 80, 40, 10, 0});              // inverted boxes
      send_box_pair('{10, 20, 30, 40, 30, 40, 10, 20});               // swapped corners
      send_box_pair('{MAXC, 0, MINC, 0, MINC, 0, MAXC, 0});           // coincident, extremes
      send_box_pair('{MINC, MINC, MINC, MINC, MINC, MAXC, MINC, MAXC});
      wait_drained();
   endtask

   task automatic test_random(int count);
      box_pair_type b;
      int           burst, span, mode;
      for (int i = 0; i < count; ) begin
         burst = $urandom_range(1, 30);
         for (int j = 0; j < burst && i < count; j++, i++) begin
            mode = $urandom_range(0, 9);
            span = (mode < 4) ? 0 : (mode < 8) ? 2000 : 3;
            b.pl = rand_coord(span); b.pt = rand_coord(span);
            b.pr = rand_coord(span); b.pb = rand_coord(span);
            if (mode == 9) begin
               // same centers, different box shapes
               b.cl = CW'(b.pl + 5); b.cr = CW'(b.pr - 5);
               b.ct = CW'(b.pt - 7); b.cb = CW'(b.pb + 7);
            end else begin
               b.cl = rand_coord(span); b.ct = rand_coord(span);
               b.cr = rand_coord(span); b.cb = rand_coord(span);
            end
            send_box_pair(b);
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
         if (i % 300 < burst && $urandom_range(0, 1) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(950);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (fail_count == 0 && expected_dirs.size() == 0)
         $display("** box_motion_direction_top: PASSED **");
      else
         $display("** box_motion_direction_top: FAILED **");
      $finish;
   end

endmodule
